// File: rtl/pfrt_pkg.sv
// ============================================================================
// pfrt_pkg
// Shared types and constants of the port-forwarding rule table.
// ============================================================================
package pfrt_pkg;

  // Number of rule slots in the table
  localparam int TABLE_ENTRIES = 16;

  // Slot index width (at least one bit)
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Index of the last slot
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Stream payload widths
  localparam int IN_DATA_W  = 40;  // proto, guest_port, host_port_num, padded
  localparam int OUT_DATA_W = 8;   // status, slot, padded
  localparam int SLOT_W     = 4;

  // Request kinds carried in in_tuser
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUP_GUEST = 3'd1,
    ST_DUP_HOST  = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } pfrt_status_t;

  // One stored rule, without its valid bit
  typedef struct packed {
    logic        proto;
    logic [15:0] guest_port;
    logic [15:0] host_side_port;
  } pfrt_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             start;    // capture request, clear walk tracking
    logic             rd_en;    // read one slot
    logic [IDX_W-1:0] rd_addr;  // slot to read
    logic             commit;   // update table, load result register
  } pfrt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;  // result register holds a transaction not yet taken
  } pfrt_stat_t;

endpackage

// File: rtl/pfrt_ctrl.sv
// ============================================================================
// pfrt_ctrl
// Sequencer: accept a request, walk every slot, then commit the result.
// ============================================================================
module pfrt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pfrt_pkg::pfrt_stat_t stat,
  output pfrt_pkg::pfrt_cmd_t  cmd
);
  import pfrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             commit_ok;

  assign commit_ok = (state_r == S_FINISH) && !stat.out_busy;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd.start   = (state_r == S_IDLE) && in_tvalid;
    cmd.rd_en   = (state_r == S_WALK);
    cmd.rd_addr = cnt_r;
    cmd.commit  = commit_ok;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (commit_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/pfrt_dpath.sv
// ============================================================================
// pfrt_dpath
// Rule storage, per-slot compare, result selection and result register.
// ============================================================================
module pfrt_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_mode,
  input  logic                          req_proto,
  input  logic [15:0]                   req_guest_port,
  input  logic [15:0]                   req_host_port_num,
  input  pfrt_pkg::pfrt_cmd_t           cmd,
  output pfrt_pkg::pfrt_stat_t          stat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output pfrt_pkg::pfrt_status_t        res_status,
  output logic [pfrt_pkg::SLOT_W-1:0]   res_slot
);
  import pfrt_pkg::*;

  // Rule storage and valid bits
  pfrt_entry_t              mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  // Captured request
  logic        mode_r;
  pfrt_entry_t req_r;

  // Read stage
  pfrt_entry_t      rd_data_r;
  logic             rd_vld_r;
  logic             rd_en_r;
  logic [IDX_W-1:0] rd_idx_r;

  // Walk tracking
  logic             hit_r;
  pfrt_status_t     hit_code_r;
  logic [IDX_W-1:0] hit_slot_r;
  logic             empty_found_r;
  logic [IDX_W-1:0] empty_slot_r;

  // Result register
  logic         out_valid_r;
  pfrt_status_t out_status_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic             proto_eq, guest_eq, host_eq;
  logic             hit_now, empty_now;
  pfrt_status_t     code_now;
  pfrt_status_t     fin_status;
  logic [IDX_W-1:0] fin_slot;
  logic             wr_en, clr_en;

  assign proto_eq = (rd_data_r.proto == req_r.proto);
  assign guest_eq = (rd_data_r.guest_port == req_r.guest_port);
  assign host_eq  = (rd_data_r.host_side_port == req_r.host_side_port);

  assign hit_now = rd_en_r && rd_vld_r && proto_eq &&
                   ((mode_r == MODE_REMOVE) ? (guest_eq && host_eq)
                                            : (guest_eq || host_eq));
  assign empty_now = rd_en_r && !rd_vld_r;

  always_comb begin
    if (mode_r == MODE_REMOVE) begin
      code_now = ST_REMOVED;
    end else if (guest_eq) begin
      code_now = ST_DUP_GUEST;
    end else begin
      code_now = ST_DUP_HOST;
    end
  end

  // Pick the final outcome once the walk is over
  always_comb begin
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    fin_status = ST_FULL;
    fin_slot   = '0;
    if (hit_r) begin
      fin_status = hit_code_r;
      fin_slot   = hit_slot_r;
      clr_en     = (mode_r == MODE_REMOVE);
    end else if (mode_r == MODE_REMOVE) begin
      fin_status = ST_NOT_FOUND;
    end else if (empty_found_r) begin
      fin_status = ST_ADDED;
      fin_slot   = empty_slot_r;
      wr_en      = 1'b1;
    end
  end

  // Storage: write on commit, registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[empty_slot_r] <= req_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r                <= req_mode;
      req_r.proto           <= req_proto;
      req_r.guest_port      <= req_guest_port;
      req_r.host_side_port  <= req_host_port_num;
    end
    if (cmd.rd_en) begin
      rd_vld_r <= valid_r[cmd.rd_addr];
      rd_idx_r <= cmd.rd_addr;
    end
    if (hit_now && !hit_r) begin
      hit_code_r <= code_now;
      hit_slot_r <= rd_idx_r;
    end
    if (empty_now && !empty_found_r) begin
      empty_slot_r <= rd_idx_r;
    end
    if (cmd.commit) begin
      out_status_r <= fin_status;
      out_slot_r   <= SLOT_W'(fin_slot);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      rd_en_r       <= 1'b0;
      hit_r         <= 1'b0;
      empty_found_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_en_r <= cmd.rd_en;
      if (cmd.start) begin
        hit_r         <= 1'b0;
        empty_found_r <= 1'b0;
      end else begin
        if (hit_now) begin
          hit_r <= 1'b1;
        end
        if (empty_now) begin
          empty_found_r <= 1'b1;
        end
      end
      if (cmd.commit && wr_en) begin
        valid_r[empty_slot_r] <= 1'b1;
      end
      if (cmd.commit && clr_en) begin
        valid_r[hit_slot_r] <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_busy = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign res_status    = out_status_r;
  assign res_slot      = out_slot_r;

endmodule

// File: rtl/port_forward_rule_table_core.sv
// ============================================================================
// port_forward_rule_table_core
// Port-forwarding rule table with add and remove requests.
// ============================================================================
// Each input transaction is one request: add a rule or remove a rule, where a
// rule is a protocol bit, a guest port and a host port. The block walks all
// TABLE_ENTRIES slots of its rule store, one slot read per cycle through the
// single read port of the store, and answers with exactly one result
// transaction: added, duplicate guest port, duplicate host port, table full,
// removed or not found, together with the slot concerned (0 when none).
// An add is refused by the lowest valid slot of the same protocol whose guest
// port (checked first) or host port matches; otherwise it lands in the lowest
// empty slot. A remove clears the lowest valid slot matching all three fields.
// From acceptance to the result register a request goes through one read per
// slot, the compare of the last slot and the commit, so the slot walk sets the
// time. Requests are handled one at a time; the next one is accepted only after
// the previous one has committed its result. The result register holds a result
// while the next request is already accepted and walked, so a slow consumer only
// stalls the block when a second result is ready before the first was taken.
// Reset empties the table at once.
// ============================================================================
module port_forward_rule_table_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pfrt_pkg::IN_DATA_W-1:0]      in_tdata,   // proto, guest_port, host_port_num
  input  logic                                in_tuser,   // mode: 0 add, 1 remove
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pfrt_pkg::OUT_DATA_W-1:0]     out_tdata   // status, slot
);
  import pfrt_pkg::*;

  pfrt_cmd_t         cmd;
  pfrt_stat_t        stat;
  pfrt_status_t      res_status;
  logic [SLOT_W-1:0] res_slot;

  // Sequence the walk over the rule slots
  pfrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the rules, compare each slot, register the result
  pfrt_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_mode          (in_tuser),
    .req_proto         (in_tdata[0]),
    .req_guest_port    (in_tdata[16:1]),
    .req_host_port_num (in_tdata[32:17]),
    .cmd               (cmd),
    .stat              (stat),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .res_status        (res_status),
    .res_slot          (res_slot)
  );

  // Pack the result: status in the low bits, slot above, zero padding on top
  assign out_tdata = {{(OUT_DATA_W - 3 - SLOT_W){1'b0}}, res_slot, res_status};

endmodule
